### rtl/polyblep_oscillator_defines.svh
// ----------------------------------------------------------------------------
// polyblep_oscillator_defines: assertion macros
// Short forms for the concurrent checks of the oscillator. They expect
// clk_i and rst_ni in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef POLYBLEP_OSCILLATOR_DEFINES_SVH
`define POLYBLEP_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PBO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PBO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pbo_pkg.sv
// ----------------------------------------------------------------------------
// pbo_pkg
// Shared constants and the quarter-wave sine point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pbo_pkg;

  localparam int unsigned FREQ_W    = 25;  // frequency, 8 fractional bits
  localparam int unsigned PW_W      = 16;  // pulse width, Q1.15
  localparam int unsigned SR_W      = 18;  // sample rate in Hz
  localparam int unsigned SAW_W     = 16;
  localparam int unsigned PULSE_W   = 18;
  localparam int unsigned SINE_W    = 16;
  localparam int unsigned SINE_MAG_W = 15;
  localparam int unsigned FRAC_BITS = 16;  // blep fraction resolution
  localparam int unsigned SAT_SHIFT = 12;  // dt saturates at 2^12 >> 8 = 16.0

  localparam logic [SR_W-1:0] SR_RESET = 18'd48000;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Taylor series of sin(x), x in Q30, rounded to Q15 and capped at 32767.
  function automatic logic [SINE_MAG_W-1:0] sine_from_x(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [65:0] sum;
    logic signed [65:0] v;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed({2'b00, x});
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed({2'b00, term});
    term = ((term * x2) >> 30) / 64'd420; sum = sum + $signed({2'b00, term});
    if (sum < 0) begin
      sum = '0;
    end
    v = (sum + 66'sd16384) >>> 15;
    if (v > 66'sd32767) begin
      v = 66'sd32767;
    end
    return v[SINE_MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/polyblep_oscillator.sv
// ----------------------------------------------------------------------------
// polyblep_oscillator
// Band-limited saw, pulse and sine oscillator, one sample per request.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                 Payload
//  -------  ------------------------  -----------------------------------
//  in       in_valid_i / in_ready_o   frequency_i, pulse_width_i
//  out      out_valid_o / out_ready_i saw_out_o, pulse_out_o, sine_out_o
//  cfg      cfg_we_i (no wait)        cfg_wdata_i (sample rate in Hz)
//
//  Steps per request: accept, then the divide steps for dt (skipped when dt
//  saturates), then for each saw a select step, the blep fraction on the
//  shared compare-subtract unit and one multiply when the phase is near the
//  wrap, and a saw step; last, the load of the result.
//  Reset clears the phase to zero and the sample rate to 48000.
//  The next request is taken while a result waits in the output register;
//  a stalled output holds the sequencer in its last state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polyblep_oscillator_defines.svh"

module polyblep_oscillator #(
  parameter int unsigned PHASE_BITS       = 32,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pbo_pkg::SR_W-1:0]      cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pbo_pkg::FREQ_W-1:0]    frequency_i,
  input  wire logic signed [pbo_pkg::PW_W-1:0] pulse_width_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [pbo_pkg::SAW_W-1:0]   saw_out_o,
  output logic signed [pbo_pkg::PULSE_W-1:0] pulse_out_o,
  output logic signed [pbo_pkg::SINE_W-1:0]  sine_out_o
);

  import pbo_pkg::*;

  // dt carries 4 integer bits above the phase fraction
  localparam int unsigned DT_W  = PHASE_BITS + 4;
  localparam int unsigned CNT_W = $clog2(DT_W);
  localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int unsigned POS_W = IDX_W - 2;
  localparam int unsigned ROM_AW = $clog2(QUARTER + 1);
  localparam logic [DT_W-1:0] DT_MAX = '1;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_FRAC = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_SAW  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]             state_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   sel_q;       // 0: main phase, 1: offset phase
  logic [PHASE_BITS-1:0]  phase_q;
  logic [SR_W-1:0]        sr_q;
  logic                   out_valid_q;

  logic [DT_W-1:0]        dt_q;
  logic [DT_W-1:0]        rem_q;
  logic [DT_W-1:0]        q_q;
  logic [PHASE_BITS-1:0]  ph2_q;
  logic signed [PW_W-1:0] w_q;
  logic                   neg_q;
  logic                   blep_on_q;
  logic [33:0]            prod_q;
  logic signed [17:0]     s1_q;
  logic signed [17:0]     s2_q;

  logic                   in_fire;
  logic                   out_load;
  logic                   dt_sat;
  logic [PHASE_BITS-1:0]  ph2_d;

  // ---------------------------------------------------------------------------
  // Input side: take a request only when the sequencer is parked
  // ---------------------------------------------------------------------------
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // dt would reach 16.0 or beyond (or the rate is zero): saturate, skip divide
  assign dt_sat = (sr_q == '0) ||
                  ({5'b00000, frequency_i} >= {sr_q, {SAT_SHIFT{1'b0}}});

  // offset phase: phase + (w + 1) / 2, wrapping
  assign ph2_d = phase_q +
                 (PHASE_BITS'({~pulse_width_i[PW_W-1], pulse_width_i[PW_W-2:0]})
                  << (PHASE_BITS - 16));

  // ---------------------------------------------------------------------------
  // Shared compare-subtract unit: dt division, then both blep fractions
  // ---------------------------------------------------------------------------
  logic            step_bit;
  logic [DT_W-1:0] step_den;
  logic [DT_W-1:0] step_rem;
  logic            step_qbit;

  always_comb begin
    if (state_q == ST_DIV) begin
      step_bit = q_q[DT_W-1];
      step_den = DT_W'(sr_q);
    end else begin
      step_bit = 1'b0;
      step_den = dt_q;
    end
  end

  pbo_div_step #(
    .W(DT_W)
  ) u_step (
    .rem_i (rem_q),
    .bit_i (step_bit),
    .den_i (step_den),
    .rem_o (step_rem),
    .qbit_o(step_qbit)
  );

  // ---------------------------------------------------------------------------
  // Blep region select for the current saw phase
  // ---------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] x_sel;
  logic [PHASE_BITS:0]   one_minus;
  logic                  lt_head;
  logic                  lt_tail;
  logic [DT_W-1:0]       num_sel;

  assign x_sel     = sel_q ? ph2_q : phase_q;
  assign one_minus = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, x_sel};
  assign lt_head   = (DT_W'(x_sel) < dt_q);       // just after the wrap
  assign lt_tail   = (DT_W'(one_minus) < dt_q);   // just before the wrap
  assign num_sel   = lt_head ? DT_W'(x_sel) : DT_W'(one_minus);

  // ---------------------------------------------------------------------------
  // Square of (1 - p), rounded to Q15, and the saw value
  // ---------------------------------------------------------------------------
  logic [16:0]        u_val;
  logic [33:0]        prod;
  logic [33:0]        rnd;
  logic [15:0]        mag;
  logic signed [17:0] blep_s;
  logic signed [17:0] saw_new;

  assign u_val  = 17'h10000 - {1'b0, q_q[FRAC_BITS-1:0]};
  assign prod   = u_val * u_val;
  assign rnd    = prod_q + 34'd65536;
  assign mag    = blep_on_q ? rnd[32:17] : 16'd0;
  assign blep_s = neg_q ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  assign saw_new = $signed({2'b00, x_sel[PHASE_BITS-1 -: 15], 1'b0})
                   - 18'sd32768 - blep_s;

  // ---------------------------------------------------------------------------
  // Result assembly: pulse from unclamped saws, clamp, sine sign
  // ---------------------------------------------------------------------------
  logic signed [19:0]      psum;
  logic signed [PULSE_W-1:0] pulse_d;
  logic signed [SAW_W-1:0] saw_d;
  logic [IDX_W-1:0]        sine_idx;
  logic [ROM_AW-1:0]       rom_addr;
  logic [SINE_MAG_W-1:0]   rom_data;
  logic signed [SINE_W-1:0] sine_d;

  assign psum = 20'(s1_q) - 20'(s2_q) + 20'(w_q);

  always_comb begin
    if (psum > 20'sd98303) begin
      pulse_d = 18'sd98303;
    end else if (psum < -20'sd98304) begin
      pulse_d = -18'sd98304;
    end else begin
      pulse_d = psum[PULSE_W-1:0];
    end
    if (s1_q > 18'sd32767) begin
      saw_d = 16'sd32767;
    end else if (s1_q < -18'sd32768) begin
      saw_d = -16'sd32768;
    end else begin
      saw_d = s1_q[SAW_W-1:0];
    end
  end

  // Mirror odd quadrants, negate the second half. The phase holds still until
  // the result is loaded, so the registered read is long settled by then.
  assign sine_idx = phase_q[PHASE_BITS-1 -: IDX_W];
  assign rom_addr = sine_idx[POS_W] ?
                    (ROM_AW'(QUARTER) - ROM_AW'(sine_idx[POS_W-1:0])) :
                    ROM_AW'(sine_idx[POS_W-1:0]);

  pbo_sine_rom #(
    .QUARTER(QUARTER)
  ) u_sine_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  assign sine_d = sine_idx[IDX_W-1] ? -$signed({1'b0, rom_data}) :
                                      $signed({1'b0, rom_data});

  // ---------------------------------------------------------------------------
  // Sequencer and control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      sel_q       <= 1'b0;
      phase_q     <= '0;
      sr_q        <= SR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sr_q <= cfg_wdata_i;
      end
      // drop the result once taken, unless a new one loads in the same cycle
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            sel_q   <= 1'b0;
            cnt_q   <= CNT_W'(DT_W - 1);
            state_q <= dt_sat ? ST_SEL : ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_SEL;
          end
        end
        ST_SEL: begin
          cnt_q   <= CNT_W'(FRAC_BITS - 1);
          state_q <= (lt_head || lt_tail) ? ST_FRAC : ST_SAW;
        end
        ST_FRAC: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_SAW;
        end
        ST_SAW: begin
          if (!sel_q) begin
            sel_q   <= 1'b1;
            state_q <= ST_SEL;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free, then advance the phase
          if (out_load) begin
            out_valid_q <= 1'b1;
            phase_q     <= phase_q + dt_q[PHASE_BITS-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          w_q   <= pulse_width_i;
          ph2_q <= ph2_d;
          // top dividend bits already sit below the rate when not saturated
          rem_q <= DT_W'(frequency_i[FREQ_W-1:SAT_SHIFT]);
          q_q   <= {frequency_i[SAT_SHIFT-1:0], {(PHASE_BITS - 8){1'b0}}};
          if (dt_sat) begin
            dt_q <= DT_MAX;
          end
        end
      end
      ST_DIV: begin
        rem_q <= step_rem;
        q_q   <= {q_q[DT_W-2:0], step_qbit};
        if (cnt_q == '0) begin
          dt_q <= {q_q[DT_W-2:0], step_qbit};
        end
      end
      ST_SEL: begin
        rem_q     <= num_sel;
        neg_q     <= lt_head;
        blep_on_q <= lt_head || lt_tail;
      end
      ST_FRAC: begin
        rem_q <= step_rem;
        q_q   <= {q_q[DT_W-2:0], step_qbit};
      end
      ST_MUL: begin
        prod_q <= prod;
      end
      ST_SAW: begin
        if (!sel_q) begin
          s1_q <= saw_new;
        end else begin
          s2_q <= saw_new;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          saw_out_o   <= saw_d;
          pulse_out_o <= pulse_d;
          sine_out_o  <= sine_d;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PBO_ASSERT_NEXT(a_phase_hold, state_q != ST_DONE, $stable(phase_q),
    "phase moved outside result load")
  `PBO_ASSERT_NOW(a_div_rem, state_q == ST_DIV, rem_q < DT_W'(sr_q),
    "dt division remainder not below sample rate")
  `PBO_ASSERT_NOW(a_frac_rem, state_q == ST_FRAC, rem_q < dt_q,
    "blep fraction remainder not below dt")

endmodule

`default_nettype wire

### rtl/pbo_div_step.sv
// ----------------------------------------------------------------------------
// pbo_div_step
// One restoring-division step: shift in a bit, compare, subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module pbo_div_step #(
  parameter int unsigned W = 36
) (
  input  wire logic [W-1:0] rem_i,
  input  wire logic         bit_i,
  input  wire logic [W-1:0] den_i,
  output logic      [W-1:0] rem_o,
  output logic              qbit_o
);

  logic [W:0] trial;
  logic [W:0] diff;

  assign trial  = {rem_i, bit_i};
  assign diff   = trial - {1'b0, den_i};
  assign qbit_o = (trial >= {1'b0, den_i});
  // trial stays below the divisor when no subtract happens, so it fits W bits
  assign rem_o  = qbit_o ? diff[W-1:0] : trial[W-1:0];

endmodule

`default_nettype wire

### rtl/pbo_sine_rom.sv
// ----------------------------------------------------------------------------
// pbo_sine_rom
// Quarter-wave sine table, magnitude only, with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pbo_sine_rom #(
  parameter int unsigned QUARTER = 256
) (
  input  wire logic                           clk_i,
  input  wire logic [$clog2(QUARTER+1)-1:0]   addr_i,
  output logic      [pbo_pkg::SINE_MAG_W-1:0] data_o
);

  import pbo_pkg::*;

  logic [SINE_MAG_W-1:0] points [QUARTER+1];

  for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_pt
    localparam logic [63:0] X =
      (64'(gi) * HALF_PI_Q30 + 64'(QUARTER / 2)) / 64'(QUARTER);
    assign points[gi] = sine_from_x(X);
  end

  always_ff @(posedge clk_i) begin
    data_o <= points[addr_i];
  end

endmodule

`default_nettype wire
